// ===== sv/gda_pkg.sv =====
package gda_pkg;

	localparam int MAX_HEADS    = 4;
	localparam int MAX_KV_HEADS = 4;
	localparam int MAX_HEAD_DIM = 16;
	localparam int MAX_SEQ      = 64;
	localparam int MAX_LAYERS   = 2;

	localparam logic [1:0] KIND_QUERY = 2'd0;
	localparam logic [1:0] KIND_KEY   = 2'd1;
	localparam logic [1:0] KIND_VALUE = 2'd2;
	localparam logic [1:0] KIND_RUN   = 2'd3;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_BAD_HEADS = 2'd1;
	localparam logic [1:0] STAT_BAD_POS   = 2'd2;

	localparam logic [1:0] CFG_QUERY_HEADS = 2'd0;
	localparam logic [1:0] CFG_KV_HEADS    = 2'd1;
	localparam logic [1:0] CFG_HEAD_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_SCORE_SCALE = 2'd3;

	typedef struct packed {
		logic [2:0]  qh;
		logic [2:0]  kvh;
		logic [4:0]  hw;
		logic [15:0] scale;
	} gda_cfg_t;

	typedef struct packed {
		logic        we_q;
		logic        we_k;
		logic        we_v;
		logic [5:0]  addr;
		logic [15:0] data;
	} gda_load_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] pos;
		logic       layer;
	} gda_run_t;

	// q1.16 table of 2^(-j/16)
	function automatic logic [16:0] exp_tbl(input logic [4:0] j);
		logic [16:0] r;
		begin
			case (j)
				5'd0:  r = 17'd65536;
				5'd1:  r = 17'd62757;
				5'd2:  r = 17'd60097;
				5'd3:  r = 17'd57549;
				5'd4:  r = 17'd55109;
				5'd5:  r = 17'd52773;
				5'd6:  r = 17'd50535;
				5'd7:  r = 17'd48393;
				5'd8:  r = 17'd46341;
				5'd9:  r = 17'd44376;
				5'd10: r = 17'd42495;
				5'd11: r = 17'd40693;
				5'd12: r = 17'd38968;
				5'd13: r = 17'd37316;
				5'd14: r = 17'd35734;
				5'd15: r = 17'd34219;
				default: r = 17'd32768;
			endcase
			return r;
		end
	endfunction

	// shared kv head of a query head, for valid head counts only
	function automatic logic [1:0] kv_map(input logic [1:0] h, input logic [2:0] qh,
		input logic [2:0] kv);
		logic [1:0] r;
		begin
			if (kv == qh) begin
				r = h;
			end else if (kv == 3'd1) begin
				r = 2'd0;
			end else begin
				r = h >> 1;
			end
			return r;
		end
	endfunction

endpackage

// ===== sv/gqa_decode_attention_core.sv =====
// channel   dir  handshake             payload
// in        in   in_valid / in_stall   kind head_index dim_index element_value position layer_index
// out       out  out_valid / out_stall out_head out_dim out_value status last
// cfg       in   cfg_write             cfg_index cfg_data
// load beats write straight into the staging buffers; a run holds the input until its last result is produced
// a run first copies the staged keys and values into the cache, then per query head computes the
// softmax weights and then the results; the divider dominates short heads
// a run with bad head counts or position gives one error beat
// arst_n clears control state and resets the configuration; cache, buffers and data registers are not cleared
// out_stall holds the result register and stalls the back end sequencer
module gqa_decode_attention_core import gda_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [1:0]  head_index,
	input  logic [3:0]  dim_index,
	input  logic signed [15:0] element_value,
	input  logic [5:0]  position,
	input  logic        layer_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_head,
	output logic [3:0]  out_dim,
	output logic signed [15:0] out_value,
	output logic [1:0]  status,
	output logic        last,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	gda_cfg_t  cfg;
	gda_load_t ld;
	gda_run_t  run_in;
	gda_run_t  run_out;
	logic      run_push;
	logic      run_pop;
	logic      q_empty;
	logic      back_busy;

	gda_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .head_index(head_index), .dim_index(dim_index),
		.element_value(element_value), .position(position), .layer_index(layer_index),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.hold(!q_empty || back_busy), .cfg(cfg), .ld(ld), .run_push(run_push),
		.run(run_in)
	);

	gda_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(run_push), .push_data(run_in),
		.pop(run_pop), .pop_data(run_out), .empty(q_empty)
	);

	gda_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .ld(ld), .run_valid(!q_empty),
		.run(run_out), .run_pop(run_pop), .busy(back_busy), .out_valid(out_valid),
		.out_stall(out_stall), .out_head(out_head), .out_dim(out_dim),
		.out_value(out_value), .status(status), .last(last)
	);

endmodule

// ===== sv/gda_front.sv =====
module gda_front import gda_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [1:0]  head_index,
	input  logic [3:0]  dim_index,
	input  logic signed [15:0] element_value,
	input  logic [5:0]  position,
	input  logic        layer_index,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        hold,
	output gda_cfg_t    cfg,
	output gda_load_t   ld,
	output logic        run_push,
	output gda_run_t    run
);

	gda_cfg_t cfg_q;
	logic     acc;
	logic     bad_pos;
	logic     bad_heads;
	logic     divides;

	assign cfg      = cfg_q;
	assign in_stall = hold;
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.qh    <= 3'd4;
			cfg_q.kvh   <= 3'd4;
			cfg_q.hw    <= 5'd16;
			cfg_q.scale <= 16'd16384;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_QUERY_HEADS: cfg_q.qh    <= cfg_data[2:0];
				CFG_KV_HEADS:    cfg_q.kvh   <= cfg_data[2:0];
				CFG_HEAD_WIDTH:  cfg_q.hw    <= cfg_data[4:0];
				CFG_SCORE_SCALE: cfg_q.scale <= cfg_data;
				default: ;
			endcase
		end
	end

	assign divides = (cfg_q.kvh == 3'd1) || (cfg_q.kvh == cfg_q.qh) ||
		(cfg_q.qh == 3'd4 && cfg_q.kvh == 3'd2);
	assign bad_pos = ({1'b0, position} >= 7'(MAX_SEQ)) ||
		({1'b0, layer_index} >= 2'(MAX_LAYERS));
	assign bad_heads = (cfg_q.qh == 3'd0) || (cfg_q.qh > 3'(MAX_HEADS)) ||
		(cfg_q.kvh == 3'd0) || (cfg_q.kvh > 3'(MAX_KV_HEADS)) ||
		(cfg_q.kvh > cfg_q.qh) || !divides || (cfg_q.hw == 5'd0) ||
		(cfg_q.hw > 5'(MAX_HEAD_DIM));

	always_comb begin
		ld.we_q  = acc && (kind == KIND_QUERY);
		ld.we_k  = acc && (kind == KIND_KEY);
		ld.we_v  = acc && (kind == KIND_VALUE);
		ld.addr  = {head_index, dim_index};
		ld.data  = element_value;
		run_push = acc && (kind == KIND_RUN);
		run.pos  = position;
		run.layer = layer_index;
		if (bad_pos) begin
			run.status = STAT_BAD_POS;
		end else if (bad_heads) begin
			run.status = STAT_BAD_HEADS;
		end else begin
			run.status = STAT_OK;
		end
	end

endmodule

// ===== sv/gda_queue.sv =====
module gda_queue import gda_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  gda_run_t push_data,
	input  logic     pop,
	output gda_run_t pop_data,
	output logic     empty
);

	gda_run_t   slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign empty    = (cnt_q == 2'd0);
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && cnt_q != 2'd2) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && cnt_q != 2'd2) begin
				wr_q <= ~wr_q;
			end
			if (pop && !empty) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'((push && cnt_q != 2'd2) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

endmodule

// ===== sv/gda_back.sv =====
module gda_back import gda_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  gda_cfg_t    cfg,
	input  gda_load_t   ld,
	input  logic        run_valid,
	input  gda_run_t    run,
	output logic        run_pop,
	output logic        busy,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_head,
	output logic [3:0]  out_dim,
	output logic signed [15:0] out_value,
	output logic [1:0]  status,
	output logic        last
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ERR   = 4'd1;
	localparam logic [3:0] S_COPY  = 4'd2;
	localparam logic [3:0] S_CDRN  = 4'd3;
	localparam logic [3:0] S_SCORE = 4'd4;
	localparam logic [3:0] S_SDRN  = 4'd5;
	localparam logic [3:0] S_EXP   = 4'd6;
	localparam logic [3:0] S_EDRN  = 4'd7;
	localparam logic [3:0] S_NRD   = 4'd8;
	localparam logic [3:0] S_NLD   = 4'd9;
	localparam logic [3:0] S_NDIV  = 4'd10;
	localparam logic [3:0] S_NWR   = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;
	localparam logic [3:0] S_ODRN  = 4'd13;
	localparam logic [3:0] S_EMIT  = 4'd14;

	logic [3:0]  state_q;
	gda_run_t    run_q;
	logic [1:0]  h_q;
	logic [1:0]  kvh_q;
	logic [5:0]  t_q;
	logic [3:0]  d_q;
	logic [5:0]  idx_q;
	logic [4:0]  div_cnt_q;
	logic signed [31:0] best_q;
	logic [22:0] wsum_q;
	logic [23:0] rem_q;
	logic [16:0] dq_q;
	logic signed [15:0] res_q;

	logic signed [15:0] qbuf [64];
	logic signed [15:0] skey [64];
	logic signed [15:0] sval [64];
	logic signed [15:0] kc [8192];
	logic signed [15:0] vc [8192];
	logic signed [31:0] score_mem [64];
	logic [16:0] prob_mem [64];

	logic signed [15:0] q_rd, sk_rd, sv_rd, kc_rd, vc_rd;
	logic signed [31:0] sc_rd;
	logic [16:0] pr_rd;
	logic [12:0] rd_addr;

	// copy pipeline
	logic        c_v_s1;
	logic [5:0]  c_idx_s1;
	logic        c_we;

	// score pipeline
	logic        sc_v_s1, sc_v_s2, dv_s3, dv_s4;
	logic        sc_first_s1, sc_first_s2, sc_last_s1, sc_last_s2;
	logic [5:0]  sc_t_s1, sc_t_s2, sc_t_s3, sc_t_s4;
	logic signed [31:0] prod_s2;
	logic signed [35:0] acc_q, acc_next, dot_s3;
	logic signed [52:0] scl_s4;
	logic signed [36:0] sh37;
	logic signed [31:0] score_sat;

	// exp pipeline
	logic        ev_s1, ev_s2, ev_s3;
	logic [5:0]  e_t_s1, e_t_s2, e_t_s3;
	logic [32:0] diff;
	logic [49:0] ymul;
	logic [33:0] y_s2;
	logic [16:0] ea, eb, ab;
	logic [16:0] a_s3;
	logic [28:0] dp_s3;
	logic        big_s3;
	logic [4:0]  sh_s3;
	logic [16:0] base, w;

	// divider
	logic [33:0] num;
	logic [23:0] rem2;
	logic        ge;

	// output pipeline
	logic        ov_s1, ov_s2, ov_s3;
	logic        o_first_s1, o_first_s2, o_last_s1, o_last_s2;
	logic signed [33:0] op_s2;
	logic signed [39:0] oacc_q, oacc_next, rnd;
	logic signed [23:0] r24;

	logic        last_d, last_t, last_h, out_free, out_load, pipe_idle;
	logic [1:0]  o_head;
	logic [3:0]  o_dim;
	logic signed [15:0] o_val;
	logic [1:0]  o_stat;
	logic        o_last;

	assign last_d   = ({1'b0, d_q} == cfg.hw - 5'd1);
	assign last_t   = (t_q == run_q.pos);
	assign last_h   = ({1'b0, h_q} == cfg.qh - 3'd1);
	assign out_free = !out_valid || !out_stall;
	assign rd_addr  = {run_q.layer, t_q, kvh_q, d_q};
	assign busy     = (state_q != S_IDLE);
	assign run_pop  = (state_q == S_IDLE) && run_valid;
	assign pipe_idle = !(c_v_s1 || sc_v_s1 || sc_v_s2 || dv_s3 || dv_s4 || ev_s1 || ev_s2 ||
		ev_s3 || ov_s1 || ov_s2 || ov_s3);

	// staging and caches
	assign c_we = c_v_s1 && ({1'b0, c_idx_s1[5:4]} < cfg.kvh) &&
		({1'b0, c_idx_s1[3:0]} < cfg.hw);

	always_ff @(posedge clk) begin
		if (ld.we_q) begin
			qbuf[ld.addr] <= ld.data;
		end
		q_rd <= qbuf[{h_q, d_q}];
	end

	always_ff @(posedge clk) begin
		if (ld.we_k) begin
			skey[ld.addr] <= ld.data;
		end
		sk_rd <= skey[idx_q];
	end

	always_ff @(posedge clk) begin
		if (ld.we_v) begin
			sval[ld.addr] <= ld.data;
		end
		sv_rd <= sval[idx_q];
	end

	always_ff @(posedge clk) begin
		if (c_we) begin
			kc[{run_q.layer, run_q.pos, c_idx_s1}] <= sk_rd;
		end
		kc_rd <= kc[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (c_we) begin
			vc[{run_q.layer, run_q.pos, c_idx_s1}] <= sv_rd;
		end
		vc_rd <= vc[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (dv_s4) begin
			score_mem[sc_t_s4] <= score_sat;
		end
		sc_rd <= score_mem[t_q];
	end

	always_ff @(posedge clk) begin
		if (ev_s3) begin
			prob_mem[e_t_s3] <= w;
		end else if (state_q == S_NWR) begin
			prob_mem[t_q] <= dq_q;
		end
		pr_rd <= prob_mem[t_q];
	end

	// datapath
	assign acc_next  = (sc_first_s2 ? 36'sd0 : acc_q) + 36'(prod_s2);
	assign sh37      = scl_s4[52:16];
	assign score_sat = (sh37[36:31] == 6'h00 || sh37[36:31] == 6'h3F) ? sh37[31:0] :
		(sh37[36] ? 32'sh80000000 : 32'sh7FFFFFFF);

	assign diff = 33'({best_q[31], best_q} - {sc_rd[31], sc_rd});
	assign ymul = diff * 17'd94548;
	assign ea   = exp_tbl({1'b0, y_s2[15:12]});
	assign eb   = exp_tbl({1'b0, y_s2[15:12]} + 5'd1);
	assign ab   = ea - eb;
	assign base = a_s3 - 17'(dp_s3 >> 12);
	assign w    = big_s3 ? 17'd0 : (base >> sh_s3);

	assign num  = {pr_rd, 16'd0} + 34'(wsum_q >> 1);
	assign rem2 = {rem_q[22:0], dq_q[16]};
	assign ge   = (rem2 >= {1'b0, wsum_q});

	assign oacc_next = (o_first_s2 ? 40'sd0 : oacc_q) + 40'(op_s2);
	assign rnd       = oacc_next + 40'sd32768;
	assign r24       = rnd[39:16];

	always_ff @(posedge clk) begin
		c_idx_s1    <= idx_q;
		sc_first_s1 <= (d_q == 4'd0);
		sc_last_s1  <= last_d;
		sc_t_s1     <= t_q;
		sc_first_s2 <= sc_first_s1;
		sc_last_s2  <= sc_last_s1;
		sc_t_s2     <= sc_t_s1;
		prod_s2     <= q_rd * kc_rd;
		if (sc_v_s2) begin
			acc_q <= acc_next;
		end
		dot_s3      <= acc_next;
		sc_t_s3     <= sc_t_s2;
		scl_s4      <= dot_s3 * $signed({1'b0, cfg.scale});
		sc_t_s4     <= sc_t_s3;
		e_t_s1      <= t_q;
		e_t_s2      <= e_t_s1;
		e_t_s3      <= e_t_s2;
		y_s2        <= ymul[49:16];
		a_s3        <= ea;
		dp_s3       <= ab * y_s2[11:0];
		big_s3      <= (y_s2[33:16] >= 18'd17);
		sh_s3       <= y_s2[20:16];
		o_first_s1  <= (t_q == 6'd0);
		o_last_s1   <= last_t;
		o_first_s2  <= o_first_s1;
		o_last_s2   <= o_last_s1;
		op_s2       <= $signed({1'b0, pr_rd}) * vc_rd;
		if (ov_s2) begin
			oacc_q <= oacc_next;
		end
		if (ov_s2 && o_last_s2) begin
			res_q <= (r24[23:15] == 9'h000 || r24[23:15] == 9'h1FF) ? r24[15:0] :
				(r24[23] ? 16'sh8000 : 16'sh7FFF);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_v_s1  <= 1'b0;
			sc_v_s1 <= 1'b0;
			sc_v_s2 <= 1'b0;
			dv_s3   <= 1'b0;
			dv_s4   <= 1'b0;
			ev_s1   <= 1'b0;
			ev_s2   <= 1'b0;
			ev_s3   <= 1'b0;
			ov_s1   <= 1'b0;
			ov_s2   <= 1'b0;
			ov_s3   <= 1'b0;
		end else begin
			c_v_s1  <= (state_q == S_COPY);
			sc_v_s1 <= (state_q == S_SCORE);
			sc_v_s2 <= sc_v_s1;
			dv_s3   <= sc_v_s2 && sc_last_s2;
			dv_s4   <= dv_s3;
			ev_s1   <= (state_q == S_EXP);
			ev_s2   <= ev_s1;
			ev_s3   <= ev_s2;
			ov_s1   <= (state_q == S_OUT);
			ov_s2   <= ov_s1;
			ov_s3   <= ov_s2 && o_last_s2;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			run_q     <= '0;
			h_q       <= 2'd0;
			kvh_q     <= 2'd0;
			t_q       <= 6'd0;
			d_q       <= 4'd0;
			idx_q     <= 6'd0;
			div_cnt_q <= 5'd0;
			best_q    <= 32'sh80000000;
			wsum_q    <= 23'd0;
			rem_q     <= 24'd0;
			dq_q      <= 17'd0;
		end else begin
			if (dv_s4 && score_sat > best_q) begin
				best_q <= score_sat;
			end
			if (ev_s3) begin
				wsum_q <= wsum_q + 23'(w);
			end
			case (state_q)
				S_IDLE: begin
					if (run_valid) begin
						run_q <= run;
						idx_q <= 6'd0;
						state_q <= (run.status != STAT_OK) ? S_ERR : S_COPY;
					end
				end
				S_ERR: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_COPY: begin
					idx_q <= idx_q + 6'd1;
					if (idx_q == 6'd63) begin
						state_q <= S_CDRN;
					end
				end
				S_CDRN: begin
					if (pipe_idle) begin
						h_q     <= 2'd0;
						kvh_q   <= kv_map(2'd0, cfg.qh, cfg.kvh);
						t_q     <= 6'd0;
						d_q     <= 4'd0;
						best_q  <= 32'sh80000000;
						state_q <= S_SCORE;
					end
				end
				S_SCORE: begin
					if (last_d) begin
						d_q <= 4'd0;
						if (last_t) begin
							state_q <= S_SDRN;
						end else begin
							t_q <= t_q + 6'd1;
						end
					end else begin
						d_q <= d_q + 4'd1;
					end
				end
				S_SDRN: begin
					if (pipe_idle) begin
						t_q     <= 6'd0;
						wsum_q  <= 23'd0;
						state_q <= S_EXP;
					end
				end
				S_EXP: begin
					if (last_t) begin
						state_q <= S_EDRN;
					end else begin
						t_q <= t_q + 6'd1;
					end
				end
				S_EDRN: begin
					if (pipe_idle) begin
						t_q     <= 6'd0;
						state_q <= S_NRD;
					end
				end
				S_NRD: begin
					state_q <= S_NLD;
				end
				S_NLD: begin
					rem_q     <= {7'd0, num[33:17]};
					dq_q      <= num[16:0];
					div_cnt_q <= 5'd0;
					state_q   <= S_NDIV;
				end
				S_NDIV: begin
					rem_q     <= ge ? rem2 - {1'b0, wsum_q} : rem2;
					dq_q      <= {dq_q[15:0], ge};
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd16) begin
						state_q <= S_NWR;
					end
				end
				S_NWR: begin
					if (last_t) begin
						t_q     <= 6'd0;
						d_q     <= 4'd0;
						state_q <= S_OUT;
					end else begin
						t_q     <= t_q + 6'd1;
						state_q <= S_NRD;
					end
				end
				S_OUT: begin
					if (last_t) begin
						state_q <= S_ODRN;
					end else begin
						t_q <= t_q + 6'd1;
					end
				end
				S_ODRN: begin
					if (pipe_idle) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						t_q <= 6'd0;
						if (last_d) begin
							d_q <= 4'd0;
							if (last_h) begin
								state_q <= S_IDLE;
							end else begin
								h_q     <= h_q + 2'd1;
								kvh_q   <= kv_map(h_q + 2'd1, cfg.qh, cfg.kvh);
								best_q  <= 32'sh80000000;
								state_q <= S_SCORE;
							end
						end else begin
							d_q     <= d_q + 4'd1;
							state_q <= S_OUT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	assign out_load = out_free && (state_q == S_ERR || state_q == S_EMIT);

	always_comb begin
		if (state_q == S_ERR) begin
			o_head = 2'd0;
			o_dim  = 4'd0;
			o_val  = 16'sd0;
			o_stat = run_q.status;
			o_last = 1'b1;
		end else begin
			o_head = h_q;
			o_dim  = d_q;
			o_val  = res_q;
			o_stat = STAT_OK;
			o_last = last_d && last_h;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_head  <= o_head;
			out_dim   <= o_dim;
			out_value <= o_val;
			status    <= o_stat;
			last      <= o_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

endmodule

// ===== sv/gda_checker.sv =====
module gda_checker import gda_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  kind,
	input logic        out_valid,
	input logic        out_stall,
	input logic signed [15:0] out_value,
	input logic [1:0]  status,
	input logic        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_value))
		else $error("stalled result changed");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> last)
		else $error("error beat without last");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> out_value == 16'sd0)
		else $error("error beat with nonzero value");

	a_run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind == KIND_RUN |=> in_stall)
		else $error("input taken while run pending");

endmodule

bind gqa_decode_attention_core gda_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
	.out_valid(out_valid), .out_stall(out_stall), .out_value(out_value),
	.status(status), .last(last)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import gda_pkg::*;

	typedef struct {
		logic [1:0]         head;
		logic [3:0]         dim;
		logic signed [15:0] value;
		logic [1:0]         stat;
		logic               fin;
	} attn_beat_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] kind;
	logic [1:0] head_index;
	logic [3:0] dim_index;
	logic signed [15:0] element_value;
	logic [5:0] position;
	logic layer_index;
	logic out_valid;
	logic out_stall;
	logic [1:0] out_head;
	logic [3:0] out_dim;
	logic signed [15:0] out_value;
	logic [1:0] status;
	logic last;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	gqa_decode_attention_core uut (.*);

	attn_beat_t attn_expect[$];
	int errors = 0;
	bit quiet = 0;
	int stall_left = 0;

	int unsigned n_query, n_kv, width, scale;
	logic signed [15:0] query_mem[64];
	logic signed [15:0] key_stage[64];
	logic signed [15:0] value_stage[64];
	logic signed [15:0] key_mem[8192];
	logic signed [15:0] value_mem[8192];
	int next_pos[2];
	int seq_len;

	int unsigned pow2_tbl[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
		46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned cache_at(int unsigned l, int unsigned t, int unsigned g,
		int unsigned d);
		return ((l * 64 + t) * 4 + g) * 16 + d;
	endfunction

	function automatic longint unsigned softmax_weight(longint unsigned diff);
		longint unsigned y, yi, a, b, r, j, base;
		y = (diff * 64'd94548) >> 16;
		yi = y >> 16;
		if (yi >= 17) begin
			return 0;
		end
		j = (y >> 12) & 15;
		r = y & 12'hFFF;
		a = pow2_tbl[j];
		b = pow2_tbl[j + 1];
		base = a - (((a - b) * r) >> 12);
		return base >> yi;
	endfunction

	function automatic bit heads_bad();
		return n_query < 1 || n_query > MAX_HEADS || n_kv < 1 || n_kv > MAX_KV_HEADS ||
			n_kv > n_query || (n_query % n_kv) != 0 || width < 1 || width > MAX_HEAD_DIM;
	endfunction

	task automatic compute_attention(int unsigned pos, int unsigned layer);
		attn_beat_t b;
		longint sc[64];
		longint unsigned w[64];
		longint dot, s, best, acc, r;
		longint unsigned wsum;
		int unsigned grp, kvh;
		if (heads_bad()) begin
			b = '{0, 0, 0, STAT_BAD_HEADS, 1'b1};
			attn_expect.push_back(b);
			return;
		end
		for (int g = 0; g < n_kv; g++) begin
			for (int d = 0; d < width; d++) begin
				key_mem[cache_at(layer, pos, g, d)] = key_stage[g * 16 + d];
				value_mem[cache_at(layer, pos, g, d)] = value_stage[g * 16 + d];
			end
		end
		grp = n_query / n_kv;
		for (int h = 0; h < n_query; h++) begin
			kvh = h / grp;
			best = -64'sd2147483648;
			for (int t = 0; t <= pos; t++) begin
				dot = 0;
				for (int d = 0; d < width; d++) begin
					dot += longint'(query_mem[h * 16 + d]) *
						longint'(key_mem[cache_at(layer, t, kvh, d)]);
				end
				s = (dot * longint'(scale)) >>> 16;
				if (s > 64'sd2147483647) s = 64'sd2147483647;
				if (s < -64'sd2147483648) s = -64'sd2147483648;
				sc[t] = s;
				if (s > best) best = s;
			end
			wsum = 0;
			for (int t = 0; t <= pos; t++) begin
				w[t] = softmax_weight(longint'(best - sc[t]));
				wsum += w[t];
			end
			for (int t = 0; t <= pos; t++) begin
				w[t] = ((w[t] << 16) + wsum / 2) / wsum;
			end
			for (int d = 0; d < width; d++) begin
				acc = 0;
				for (int t = 0; t <= pos; t++) begin
					acc += longint'(w[t]) * longint'(value_mem[cache_at(layer, t, kvh, d)]);
				end
				r = (acc + 32768) >>> 16;
				if (r > 32767) r = 32767;
				if (r < -32768) r = -32768;
				b = '{h[1:0], d[3:0], r[15:0], STAT_OK, 1'b0};
				attn_expect.push_back(b);
			end
		end
		attn_expect[attn_expect.size() - 1].fin = 1'b1;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_beat(logic [1:0] k, logic [1:0] h, logic [3:0] d, logic [15:0] v,
		logic [5:0] p, logic l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		head_index <= h;
		dim_index <= d;
		element_value <= v;
		position <= p;
		layer_index <= l;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		case (k)
			KIND_QUERY: query_mem[h * 16 + d] = v;
			KIND_KEY: key_stage[h * 16 + d] = v;
			KIND_VALUE: value_stage[h * 16 + d] = v;
			default: compute_attention(p, l);
		endcase
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (attn_expect.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_config(int unsigned qh, int unsigned kv, int unsigned hw,
		int unsigned sc);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= CFG_QUERY_HEADS;
		cfg_data <= 16'(qh);
		@(posedge clk);
		cfg_index <= CFG_KV_HEADS;
		cfg_data <= 16'(kv);
		@(posedge clk);
		cfg_index <= CFG_HEAD_WIDTH;
		cfg_data <= 16'(hw);
		@(posedge clk);
		cfg_index <= CFG_SCORE_SCALE;
		cfg_data <= 16'(sc);
		@(posedge clk);
		cfg_write <= 1'b0;
		n_query = qh & 7;
		n_kv = kv & 7;
		width = hw & 31;
		scale = sc & 16'hFFFF;
		next_pos[0] = 0;
		next_pos[1] = 0;
	endtask

	function automatic logic [15:0] rand_elem();
		if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 2047) - 1024);
	endfunction

	// positions run in order within a layer so no cache entry is read unwritten
	task automatic run_step(logic l);
		int p;
		if (next_pos[l] > 0 && $urandom_range(0, 4) == 0) begin
			p = $urandom_range(0, next_pos[l] - 1);
		end else begin
			if (next_pos[l] >= seq_len || next_pos[l] >= MAX_SEQ) next_pos[l] = 0;
			p = next_pos[l];
		end
		send_beat(KIND_RUN, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
			16'($urandom_range(0, 65535)), 6'(p), l);
		if (!heads_bad() && p == next_pos[l]) next_pos[l]++;
	endtask

	task automatic fill_all(bit extreme);
		logic [15:0] pat[6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0100, 16'hFF00, 16'h0001};
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 64; i++) begin
				send_beat(k[1:0], i[5:4], i[3:0], extreme ? pat[(i + k) % 6] : rand_elem(),
					6'd0, 1'b0);
			end
		end
	endtask

	task automatic test_reset_config();
		seq_len = 64;
		fill_all(1);
		send_beat(KIND_RUN, 2'd0, 4'd0, 16'd0, 6'd0, 1'b0);
		send_beat(KIND_RUN, 2'd0, 4'd0, 16'd0, 6'd1, 1'b0);
		send_beat(KIND_RUN, 2'd0, 4'd0, 16'd0, 6'd0, 1'b1);
		next_pos[0] = 2;
		next_pos[1] = 1;
	endtask

	task automatic test_bad_heads();
		int unsigned bad[7][3] = '{'{0, 1, 4}, '{5, 1, 4}, '{4, 0, 4}, '{3, 2, 4},
			'{2, 4, 4}, '{4, 4, 0}, '{4, 4, 17}};
		for (int i = 0; i < 7; i++) begin
			set_config(bad[i][0], bad[i][1], bad[i][2], 16384);
			send_beat(KIND_RUN, 2'd0, 4'd0, 16'd0, 6'($urandom_range(0, 63)),
				1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_long_sequence();
		set_config(1, 1, 1, 65535);
		seq_len = 64;
		for (int p = 0; p < MAX_SEQ; p++) begin
			if (p % 2 == 0) begin
				send_beat(KIND_KEY, 2'd0, 4'd0, rand_elem(), 6'd0, 1'b0);
				send_beat(KIND_VALUE, 2'd0, 4'd0, rand_elem(), 6'd0, 1'b0);
			end
			run_step(1'b1);
		end
	endtask

	task automatic test_random();
		int unsigned pairs[8][2] = '{'{4, 4}, '{4, 2}, '{4, 1}, '{2, 2}, '{2, 1}, '{1, 1},
			'{3, 1}, '{3, 3}};
		int unsigned hw, sc;
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 2))
				0: hw = 1;
				1: hw = 16;
				default: hw = $urandom_range(1, 16);
			endcase
			case ($urandom_range(0, 3))
				0: sc = 0;
				1: sc = 65535;
				2: sc = 16384;
				default: sc = $urandom_range(0, 65535);
			endcase
			set_config(pairs[ph][0], pairs[ph][1], hw, sc);
			quiet = (ph == 3);
			seq_len = $urandom_range(4, 12);
			for (int i = 0; i < 20; i++) begin
				if ($urandom_range(0, 99) < 65) begin
					send_beat(2'($urandom_range(0, 2)), 2'($urandom_range(0, 3)),
						4'($urandom_range(0, 15)), rand_elem(), 6'($urandom_range(0, 63)),
						1'($urandom_range(0, 1)));
				end else begin
					run_step(1'($urandom_range(0, 1)));
				end
			end
		end
		quiet = 0;
	endtask

	task automatic report(string what);
		errors++;
		$display("error at %0t: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		attn_beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (attn_expect.size() == 0) begin
				report("beat with nothing expected");
			end else begin
				e = attn_expect.pop_front();
				if (out_head !== e.head || out_dim !== e.dim || out_value !== e.value ||
					status !== e.stat || last !== e.fin) begin
					report($sformatf("beat h%0d d%0d v%0d s%0d l%0d, expected h%0d d%0d v%0d s%0d l%0d",
						out_head, out_dim, out_value, status, last,
						e.head, e.dim, e.value, e.stat, e.fin));
				end
			end
		end
	end

	initial begin
		#100_000_000;
		$display("gqa_decode_attention_core verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		kind = KIND_QUERY;
		head_index = 2'd0;
		dim_index = 4'd0;
		element_value = 16'sd0;
		position = 6'd0;
		layer_index = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_QUERY_HEADS;
		cfg_data = 16'd0;
		n_query = 4;
		n_kv = 4;
		width = 16;
		scale = 16384;
		next_pos[0] = 0;
		next_pos[1] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_bad_heads();
		test_long_sequence();
		test_random();
		wait_idle();
		if (errors == 0) begin
			$display("gqa_decode_attention_core verification clean");
		end else begin
			$display("gqa_decode_attention_core verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/gda_pkg.sv
sv/gda_front.sv
sv/gda_queue.sv
sv/gda_back.sv
sv/gqa_decode_attention_core.sv
sv/gda_checker.sv
test/tb.sv
